@@ hw/rtl/regularized_loss_accumulator_macros.svh @@
// Assertion helpers used by the loss accumulator.
`ifndef REGULARIZED_LOSS_ACCUMULATOR_MACROS_SVH
`define REGULARIZED_LOSS_ACCUMULATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RLA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("loss accumulator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("loss accumulator assertion failed");

`endif

@@ hw/rtl/rla_pkg.sv @@
package rla_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 48;
    localparam int IN_FRAC  = 8;
    localparam int CFG_W    = 24;
    localparam int MODE_W   = 2;
    localparam int ACT_W    = 2;

    // Magnitude of a sample difference needs one bit more than a sample.
    localparam int MAG_W  = SAMPLE_W + 1;
    localparam int TERM_W = 2 * MAG_W;

    // The final multiply is split into two partial products.
    localparam int LO_W   = SUM_W / 2;
    localparam int HI_W   = SUM_W - LO_W;
    localparam int PLO_W  = LO_W + CFG_W;
    localparam int PHI_W  = HI_W + CFG_W;
    localparam int PROD_W = SUM_W + CFG_W;

    localparam int DROP_SHIFT = 16;
    localparam int PEN_SHIFT  = 17;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int IDX_LSB    = 2;
    localparam int IDX_W      = APB_ADDR_W - IDX_LSB;

    localparam logic [MODE_W-1:0] MODE_ABS  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SQ   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DROP = 2'd2;

    localparam logic [ACT_W-1:0] ACT_PAIR   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WEIGHT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FINISH = 2'd2;

    localparam logic [IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_LAMBDA = 2'd1;
    localparam logic [IDX_W-1:0] REG_SCALE  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_RESET   = MODE_SQ;
    localparam logic [CFG_W-1:0]  LAMBDA_RESET = 24'd0;
    localparam logic [CFG_W-1:0]  SCALE_RESET  = 24'd65536;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

endpackage

@@ hw/rtl/rla_req_if.sv @@
interface rla_req_if;
    logic                                valid;
    logic                                ready;
    logic [rla_pkg::ACT_W-1:0]           action;
    logic signed [rla_pkg::SAMPLE_W-1:0] first_value;
    logic signed [rla_pkg::SAMPLE_W-1:0] second_value;

    modport source (output valid, action, first_value, second_value, input ready);
    modport sink (input valid, action, first_value, second_value, output ready);
endinterface

@@ hw/rtl/rla_res_if.sv @@
interface rla_res_if;
    logic                       valid;
    logic                       ready;
    logic [rla_pkg::SUM_W-1:0]  loss_value;
    logic                       saturated;

    modport source (output valid, loss_value, saturated, input ready);
    modport sink (input valid, loss_value, saturated, output ready);
endinterface

@@ hw/rtl/regularized_loss_accumulator.sv @@
// A finish request passes the input stage, the accumulate stage, the finish pipeline and the output register.
// Pair and weight requests produce no result and are folded into the sums from the accumulate stage.
// Throughput: one request per cycle; a finish held by a full output register stalls intake
// only once it reaches the accumulate stage, so pairs and weights keep flowing before it.
// Reset (synchronous, active low): sums, the overflow flag and valids clear; loss_mode resets to 1,
// penalty_strength to 0 and dropout_scale to 1.0.
`include "regularized_loss_accumulator_macros.svh"

module regularized_loss_accumulator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    rla_req_if.sink                             i_req,
    rla_res_if.source                           o_res,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rla_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [rla_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [rla_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    // Configuration registers
    logic [rla_pkg::MODE_W-1:0] r_mode;
    logic [rla_pkg::CFG_W-1:0]  r_lambda;
    logic [rla_pkg::CFG_W-1:0]  r_scale;
    logic                       cfg_wr;
    logic [rla_pkg::IDX_W-1:0]  cfg_idx;

    // Input stage
    logic                                r_a_v;
    logic [rla_pkg::ACT_W-1:0]           r_a_act;
    logic [rla_pkg::MODE_W-1:0]          r_a_mode;
    logic signed [rla_pkg::SAMPLE_W-1:0] r_a_first;
    logic signed [rla_pkg::SAMPLE_W-1:0] r_a_second;
    logic signed [rla_pkg::MAG_W-1:0]    n_diff;
    logic signed [rla_pkg::MAG_W-1:0]    n_wext;
    logic [rla_pkg::MAG_W-1:0]           n_mag;
    logic [rla_pkg::TERM_W-1:0]          n_term;

    // Accumulate stage
    logic                        r_b_v;
    logic [rla_pkg::ACT_W-1:0]   r_b_act;
    logic [rla_pkg::MODE_W-1:0]  r_b_mode;
    logic [rla_pkg::TERM_W-1:0]  r_b_term;
    logic [rla_pkg::SUM_W-1:0]   r_err_sum;
    logic [rla_pkg::SUM_W-1:0]   r_pen_sum;
    logic                        r_ovf;
    logic [rla_pkg::SUM_W:0]     n_err_add;
    logic [rla_pkg::SUM_W:0]     n_pen_add;
    logic                        b_fin;

    // Finish pipeline
    logic                        r_c_v;
    logic                        r_c_drop;
    logic                        r_c_l1;
    logic [rla_pkg::SUM_W-1:0]   r_c_err;
    logic [rla_pkg::SUM_W-1:0]   r_c_pen;
    logic                        r_c_flag;
    logic [rla_pkg::SUM_W-1:0]   n_x;
    logic [rla_pkg::CFG_W-1:0]   n_k;

    logic                        r_d_v;
    logic                        r_d_drop;
    logic [rla_pkg::PLO_W-1:0]   r_d_plo;
    logic [rla_pkg::PHI_W-1:0]   r_d_phi;
    logic [rla_pkg::SUM_W-1:0]   r_d_err;
    logic                        r_d_flag;
    logic [rla_pkg::PROD_W-1:0]  n_full;
    logic [rla_pkg::PROD_W-1:0]  n_shr;
    logic                        n_mul_sat;

    logic                        r_e_v;
    logic                        r_e_drop;
    logic [rla_pkg::SUM_W-1:0]   r_e_mul;
    logic [rla_pkg::SUM_W-1:0]   r_e_err;
    logic                        r_e_flag;
    logic [rla_pkg::SUM_W:0]     n_loss_add;
    logic [rla_pkg::SUM_W-1:0]   n_loss;
    logic                        n_sat;

    // Output register
    logic                        r_out_v;
    logic [rla_pkg::SUM_W-1:0]   r_out_loss;
    logic                        r_out_sat;

    // Flow control
    logic out_free;
    logic e_rdy;
    logic d_rdy;
    logic c_rdy;
    logic b_go;
    logic b_rdy;
    logic a_rdy;

    assign out_free = !r_out_v || o_res.ready;
    assign e_rdy    = !r_e_v || out_free;
    assign d_rdy    = !r_d_v || e_rdy;
    assign c_rdy    = !r_c_v || d_rdy;
    assign b_fin    = (r_b_act == rla_pkg::ACT_FINISH);
    // Only a finish request needs room in the finish pipeline.
    assign b_go     = r_b_v && (!b_fin || c_rdy);
    assign b_rdy    = !r_b_v || b_go;
    assign a_rdy    = !r_a_v || b_rdy;
    assign i_req.ready = a_rdy;

    // ---------------------------------------------------------------- configuration
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[rla_pkg::APB_ADDR_W-1:rla_pkg::IDX_LSB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= rla_pkg::MODE_RESET;
            r_lambda <= rla_pkg::LAMBDA_RESET;
            r_scale  <= rla_pkg::SCALE_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                rla_pkg::REG_MODE:   r_mode   <= pwdata[rla_pkg::MODE_W-1:0];
                rla_pkg::REG_LAMBDA: r_lambda <= pwdata[rla_pkg::CFG_W-1:0];
                rla_pkg::REG_SCALE:  r_scale  <= pwdata[rla_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            rla_pkg::REG_MODE:   prdata = rla_pkg::APB_DATA_W'(r_mode);
            rla_pkg::REG_LAMBDA: prdata = rla_pkg::APB_DATA_W'(r_lambda);
            rla_pkg::REG_SCALE:  prdata = rla_pkg::APB_DATA_W'(r_scale);
            default:             prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (a_rdy) begin
            r_a_v <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_rdy && i_req.valid) begin
            r_a_act    <= i_req.action;
            r_a_mode   <= r_mode;
            r_a_first  <= i_req.first_value;
            r_a_second <= i_req.second_value;
        end
    end

    always_comb begin
        n_diff = rla_pkg::MAG_W'(r_a_first) - rla_pkg::MAG_W'(r_a_second);
        n_wext = rla_pkg::MAG_W'(r_a_first);
        if (r_a_act == rla_pkg::ACT_PAIR) begin
            n_mag = n_diff[rla_pkg::MAG_W-1] ? rla_pkg::MAG_W'(-n_diff)
                                             : rla_pkg::MAG_W'(n_diff);
        end else begin
            n_mag = n_wext[rla_pkg::MAG_W-1] ? rla_pkg::MAG_W'(-n_wext)
                                             : rla_pkg::MAG_W'(n_wext);
        end
        if (r_a_mode == rla_pkg::MODE_ABS) begin
            n_term = rla_pkg::TERM_W'(n_mag) << rla_pkg::IN_FRAC;
        end else begin
            n_term = rla_pkg::TERM_W'(n_mag) * rla_pkg::TERM_W'(n_mag);
        end
    end

    // ---------------------------------------------------------------- accumulate stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (b_rdy) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_rdy && r_a_v) begin
            r_b_act  <= r_a_act;
            r_b_mode <= r_a_mode;
            r_b_term <= n_term;
        end
    end

    assign n_err_add = {1'b0, r_err_sum} + {1'b0, rla_pkg::SUM_W'(r_b_term)};
    assign n_pen_add = {1'b0, r_pen_sum} + {1'b0, rla_pkg::SUM_W'(r_b_term)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_sum <= '0;
            r_pen_sum <= '0;
            r_ovf     <= 1'b0;
        end else if (b_go) begin
            case (r_b_act)
                rla_pkg::ACT_PAIR: begin
                    r_err_sum <= n_err_add[rla_pkg::SUM_W] ? rla_pkg::SUM_MAX
                                                           : n_err_add[rla_pkg::SUM_W-1:0];
                    r_ovf     <= r_ovf | n_err_add[rla_pkg::SUM_W];
                end
                rla_pkg::ACT_WEIGHT: begin
                    if (r_b_mode != rla_pkg::MODE_DROP) begin
                        r_pen_sum <= n_pen_add[rla_pkg::SUM_W] ? rla_pkg::SUM_MAX
                                                               : n_pen_add[rla_pkg::SUM_W-1:0];
                        r_ovf     <= r_ovf | n_pen_add[rla_pkg::SUM_W];
                    end
                end
                rla_pkg::ACT_FINISH: begin
                    r_err_sum <= '0;
                    r_pen_sum <= '0;
                    r_ovf     <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- finish: partial products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (c_rdy) begin
            r_c_v <= b_go && b_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_go && b_fin) begin
            r_c_drop <= (r_b_mode == rla_pkg::MODE_DROP);
            r_c_l1   <= (r_b_mode == rla_pkg::MODE_ABS);
            r_c_err  <= r_err_sum;
            r_c_pen  <= r_pen_sum;
            r_c_flag <= r_ovf;
        end
    end

    assign n_x = r_c_drop ? r_c_err : r_c_pen;
    assign n_k = r_c_drop ? r_scale : r_lambda;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (d_rdy) begin
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_rdy && r_c_v) begin
            r_d_drop <= r_c_drop;
            r_d_plo  <= rla_pkg::PLO_W'(n_x[rla_pkg::LO_W-1:0]) * rla_pkg::PLO_W'(n_k);
            r_d_phi  <= rla_pkg::PHI_W'(n_x[rla_pkg::SUM_W-1:rla_pkg::LO_W])
                        * rla_pkg::PHI_W'(n_k);
            r_d_err  <= r_c_l1 ? r_c_err : (r_c_err >> 1);
            r_d_flag <= r_c_flag;
        end
    end

    // ---------------------------------------------------------------- finish: combine and scale
    always_comb begin
        n_full = (rla_pkg::PROD_W'(r_d_phi) << rla_pkg::LO_W) + rla_pkg::PROD_W'(r_d_plo);
        n_shr  = r_d_drop ? (n_full >> rla_pkg::DROP_SHIFT) : (n_full >> rla_pkg::PEN_SHIFT);
        n_mul_sat = |n_shr[rla_pkg::PROD_W-1:rla_pkg::SUM_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (e_rdy) begin
            r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_rdy && r_d_v) begin
            r_e_drop <= r_d_drop;
            r_e_mul  <= n_mul_sat ? rla_pkg::SUM_MAX : n_shr[rla_pkg::SUM_W-1:0];
            r_e_err  <= r_d_err;
            r_e_flag <= r_d_flag | n_mul_sat;
        end
    end

    // ---------------------------------------------------------------- final sum and output
    always_comb begin
        n_loss_add = {1'b0, r_e_err} + {1'b0, r_e_mul};
        if (r_e_drop) begin
            n_loss = r_e_mul;
            n_sat  = r_e_flag;
        end else begin
            n_loss = n_loss_add[rla_pkg::SUM_W] ? rla_pkg::SUM_MAX
                                                : n_loss_add[rla_pkg::SUM_W-1:0];
            n_sat  = r_e_flag | n_loss_add[rla_pkg::SUM_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_free) begin
            r_out_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_e_v) begin
            r_out_loss <= n_loss;
            r_out_sat  <= n_sat;
        end
    end

    assign o_res.valid      = r_out_v;
    assign o_res.loss_value = r_out_loss;
    assign o_res.saturated  = r_out_sat;

    // ---------------------------------------------------------------- assertions
    // A finish leaving the accumulate stage leaves all sums and the flag cleared.
    `RLA_ASSERT_NEXT(a_finish_clears, i_clk, i_rst_n, b_go && b_fin, r_err_sum == '0 && r_pen_sum == '0 && !r_ovf)
    // Saturation only ever pins a sum at its maximum, and sums never come down before a clear.
    `RLA_ASSERT_SAME(a_ovf_pins_sum, i_clk, i_rst_n, r_ovf, r_err_sum == rla_pkg::SUM_MAX || r_pen_sum == rla_pkg::SUM_MAX)
    // A finish blocked by a full finish pipeline waits in the accumulate stage.
    `RLA_ASSERT_NEXT(a_finish_waits, i_clk, i_rst_n, r_b_v && b_fin && !c_rdy, r_b_v && b_fin)

endmodule

@@ tb/tb_loss_checker.sv @@
`timescale 1ns / 100ps

module tb_loss_checker
    import rla_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rla_req_if                    req,
    rla_res_if                    res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_losses,
    output int                    o_saturated
);

    typedef struct packed {
        logic [SUM_W-1:0] loss_value;
        logic             saturated;
    } t_loss;

    t_loss expected_losses[$];

    // Shadow copy of the registers and the running sums.
    logic [MODE_W-1:0] mode;
    logic [CFG_W-1:0]  lambda;
    logic [CFG_W-1:0]  scale;
    logic [SUM_W-1:0]  err_sum;
    logic [SUM_W-1:0]  pen_sum;
    logic              overflow;

    logic [MAG_W-1:0]  diff;
    logic [MAG_W-1:0]  size_abs;
    logic [SUM_W-1:0]  wide_abs;
    logic [SUM_W-1:0]  term;
    logic [SUM_W:0]    acc;
    logic [SUM_W:0]    pen_part;
    logic [SUM_W-1:0]  err_part;
    logic              flag;
    t_loss             want;
    t_loss             got;
    int                n_bad;
    int                n_loss;
    int                n_sat;

    // Bit SUM_W of each result tells that the value was clipped to the maximum.
    function automatic logic [SUM_W:0] add_sat(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[SUM_W]) return {1'b1, SUM_MAX};
        return s;
    endfunction

    function automatic logic [SUM_W:0] mul_shift_sat(input logic [SUM_W-1:0] a,
                                                     input logic [CFG_W-1:0] b,
                                                     input int sh);
        logic [PROD_W-1:0] p;
        p = (PROD_W'(a) * PROD_W'(b)) >> sh;
        if (p > PROD_W'(SUM_MAX)) return {1'b1, SUM_MAX};
        return {1'b0, p[SUM_W-1:0]};
    endfunction

    function automatic logic [MAG_W-1:0] magnitude(input logic [MAG_W-1:0] v);
        return v[MAG_W-1] ? -v : v;
    endfunction

    initial begin
        n_bad  = 0;
        n_loss = 0;
        n_sat  = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode     = MODE_RESET;
            lambda   = LAMBDA_RESET;
            scale    = SCALE_RESET;
            err_sum  = '0;
            pen_sum  = '0;
            overflow = 1'b0;
            expected_losses.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_ADDR_W-1:IDX_LSB])
                    REG_MODE:   mode   = pwdata[MODE_W-1:0];
                    REG_LAMBDA: lambda = pwdata[CFG_W-1:0];
                    REG_SCALE:  scale  = pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end

            if (res.valid && res.ready) begin
                got.loss_value = res.loss_value;
                got.saturated  = res.saturated;
                n_loss++;
                if (got.saturated) n_sat++;
                if (expected_losses.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("[%0t] unexpected loss %h sat %b with none pending",
                                 $realtime, got.loss_value, got.saturated);
                end else begin
                    want = expected_losses.pop_front();
                    if (got.loss_value !== want.loss_value ||
                        got.saturated !== want.saturated) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("[%0t] loss expected %h sat %b, got %h sat %b",
                                     $realtime, want.loss_value, want.saturated,
                                     got.loss_value, got.saturated);
                    end
                end
            end

            if (req.valid && req.ready) begin
                case (req.action)
                    ACT_PAIR: begin
                        diff     = {req.first_value[SAMPLE_W-1], req.first_value} -
                                   {req.second_value[SAMPLE_W-1], req.second_value};
                        size_abs = magnitude(diff);
                        wide_abs = SUM_W'(size_abs);
                        term     = (mode == MODE_ABS) ? (wide_abs << IN_FRAC)
                                                      : (wide_abs * wide_abs);
                        acc      = add_sat(err_sum, term);
                        err_sum  = acc[SUM_W-1:0];
                        overflow = overflow | acc[SUM_W];
                    end
                    ACT_WEIGHT: begin
                        // Weights do not count at all while dropout is selected.
                        if (mode != MODE_DROP) begin
                            size_abs = magnitude({req.first_value[SAMPLE_W-1],
                                                  req.first_value});
                            wide_abs = SUM_W'(size_abs);
                            term     = (mode == MODE_ABS) ? (wide_abs << IN_FRAC)
                                                          : (wide_abs * wide_abs);
                            acc      = add_sat(pen_sum, term);
                            pen_sum  = acc[SUM_W-1:0];
                            overflow = overflow | acc[SUM_W];
                        end
                    end
                    ACT_FINISH: begin
                        flag = overflow;
                        if (mode == MODE_DROP) begin
                            acc  = mul_shift_sat(err_sum, scale, DROP_SHIFT);
                            flag = flag | acc[SUM_W];
                        end else begin
                            pen_part = mul_shift_sat(pen_sum, lambda, PEN_SHIFT);
                            err_part = (mode == MODE_ABS) ? err_sum : (err_sum >> 1);
                            acc      = add_sat(err_part, pen_part[SUM_W-1:0]);
                            flag     = flag | pen_part[SUM_W] | acc[SUM_W];
                        end
                        want.loss_value = acc[SUM_W-1:0];
                        want.saturated  = flag;
                        expected_losses.push_back(want);
                        err_sum  = '0;
                        pen_sum  = '0;
                        overflow = 1'b0;
                    end
                    default: ;
                endcase
            end
        end

        o_mismatches <= n_bad;
        o_pending    <= expected_losses.size();
        o_losses     <= n_loss;
        o_saturated  <= n_sat;
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import rla_pkg::*;

    localparam logic [ACT_W-1:0]    ACT_UNUSED  = 2'd3;
    localparam logic [MODE_W-1:0]   MODE_UNUSED = 2'd3;
    localparam logic [IDX_W-1:0]    REG_NONE    = 2'd3;
    localparam logic [SAMPLE_W-1:0] S_MAX       = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] S_MIN       = 16'h8000;
    localparam logic [CFG_W-1:0]    CFG_MAX     = '1;
    localparam logic [CFG_W-1:0]    CFG_ONE     = 24'h010000;
    localparam int RAND_ITEMS  = 1300;
    localparam int SETTLE      = 10;
    localparam int HOLD_CYCLES = 400;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    rla_req_if req_ch ();
    rla_res_if res_ch ();

    int mismatches;
    int pending;
    int losses;
    int sat_losses;
    int n_items;
    int n_ignored;
    int n_writes;
    bit no_idle;
    bit hold_req;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    regularized_loss_accumulator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tb_loss_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req          (req_ch),
        .res          (res_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_losses     (losses),
        .o_saturated  (sat_losses)
    );

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return S_MIN;
            1:       return S_MAX;
            2:       return '0;
            3:       return SAMPLE_W'($urandom_range(0, 511)) - 16'd256;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // Called at a clock edge; returns at the edge where the request is taken.
    task automatic send_req(input logic [ACT_W-1:0] act, input logic [SAMPLE_W-1:0] fv,
                            input logic [SAMPLE_W-1:0] sv);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.action       <= act;
        req_ch.first_value  <= fv;
        req_ch.second_value <= sv;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        if (act == ACT_UNUSED) n_ignored++;
        else n_items++;
    endtask

    task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, {IDX_LSB{1'b0}}};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        n_writes++;
    endtask

    // All losses in, then a settling wait so that pairs and weights in flight land.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_cfg(input logic [APB_DATA_W-1:0] m, input logic [APB_DATA_W-1:0] l,
                           input logic [APB_DATA_W-1:0] s);
        wait_idle();
        reg_write(REG_MODE, m);
        reg_write(REG_LAMBDA, l);
        reg_write(REG_SCALE, s);
    endtask

    initial begin
        #2500000;
        $display("end of test: mismatches");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off when asked for.
    initial begin
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 9);
                if (stall > 0) begin
                    res_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
        end
    end

    initial begin
        int                    start;
        int                    phase;
        int                    nb;
        int                    len;
        int                    r;
        logic [ACT_W-1:0]      act;
        logic [MODE_W-1:0]     pm;
        logic [CFG_W-1:0]      pl;
        logic [CFG_W-1:0]      ps;
        logic [APB_DATA_W-1:0] junk;

        n_items   = 0;
        n_ignored = 0;
        n_writes  = 0;
        no_idle   = 1'b0;
        hold_req  = 1'b0;

        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.action       <= ACT_PAIR;
        req_ch.first_value  <= '0;
        req_ch.second_value <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings and empty sums.
        send_req(ACT_FINISH, '0, '0);

        set_cfg(MODE_ABS, CFG_MAX, SCALE_RESET);
        send_req(ACT_PAIR, S_MAX, S_MIN);
        send_req(ACT_PAIR, S_MIN, S_MAX);
        send_req(ACT_PAIR, '0, '0);
        send_req(ACT_WEIGHT, S_MIN, 16'hFFFF);
        send_req(ACT_WEIGHT, S_MAX, '0);
        send_req(ACT_UNUSED, 16'h1234, 16'hEDCB);
        send_req(ACT_FINISH, 16'hFFFF, 16'hFFFF);

        set_cfg(MODE_SQ, CFG_ONE, SCALE_RESET);
        send_req(ACT_PAIR, S_MIN, S_MAX);
        send_req(ACT_PAIR, 16'h0001, 16'hFFFF);
        send_req(ACT_WEIGHT, S_MIN, S_MAX);
        send_req(ACT_WEIGHT, 16'hFFFF, '0);
        send_req(ACT_FINISH, '0, '0);

        set_cfg(MODE_DROP, '0, CFG_MAX);
        send_req(ACT_PAIR, S_MAX, S_MIN);
        send_req(ACT_WEIGHT, S_MAX, '0);
        send_req(ACT_FINISH, '0, '0);

        // A scale below one is taken as it is.
        set_cfg(MODE_DROP, '0, 24'h008000);
        send_req(ACT_PAIR, 16'h0100, 16'hFF00);
        send_req(ACT_FINISH, '0, '0);

        // Sums built under L2, then the finish arrives under dropout.
        set_cfg(MODE_SQ, CFG_MAX, SCALE_RESET);
        send_req(ACT_WEIGHT, S_MIN, '0);
        send_req(ACT_PAIR, 16'h0064, 16'hFFFD);
        wait_idle();
        reg_write(REG_MODE, MODE_DROP);
        send_req(ACT_FINISH, '0, '0);

        set_cfg(MODE_UNUSED, 24'h020000, SCALE_RESET);
        send_req(ACT_PAIR, 16'h0300, 16'hFD00);
        send_req(ACT_WEIGHT, 16'h4000, '0);
        send_req(ACT_FINISH, '0, '0);

        // A write past the last register must change nothing.
        wait_idle();
        reg_write(REG_NONE, 32'hFFFFFFFF);
        send_req(ACT_PAIR, 16'h0001, '0);
        send_req(ACT_FINISH, '0, '0);

        start = n_items;
        phase = 0;
        while (n_items - start < RAND_ITEMS) begin
            case ($urandom_range(0, 6))
                0, 1:    pm = MODE_ABS;
                2, 3:    pm = MODE_SQ;
                4, 5:    pm = MODE_DROP;
                default: pm = MODE_UNUSED;
            endcase
            case ($urandom_range(0, 3))
                0:       pl = '0;
                1:       pl = CFG_MAX;
                2:       pl = CFG_ONE;
                default: pl = CFG_W'($urandom());
            endcase
            case ($urandom_range(0, 4))
                0:       ps = SCALE_RESET;
                1:       ps = CFG_MAX;
                2:       ps = CFG_W'($urandom_range(65536, 16777215));
                3:       ps = CFG_W'($urandom_range(0, 65535));
                default: ps = CFG_W'($urandom_range(65536, 262144));
            endcase
            // Upper data bits beyond each register's width are sometimes set.
            junk = ($urandom_range(0, 3) == 0) ? $urandom() : '0;
            set_cfg((junk & ~32'h3) | APB_DATA_W'(pm),
                    (junk & ~32'hFFFFFF) | APB_DATA_W'(pl),
                    (junk & ~32'hFFFFFF) | APB_DATA_W'(ps));
            if ($urandom_range(0, 9) == 0) reg_write(REG_NONE, $urandom());
            no_idle = ($urandom_range(0, 3) == 0);

            if (phase == 3) begin
                // The result side stops for a long time while finishes keep coming,
                // so the output backs up into the request side.
                hold_req = 1'b1;
                no_idle  = 1'b1;
                repeat (40) begin
                    send_req(ACT_PAIR, pick_sample(), pick_sample());
                    send_req(ACT_FINISH, pick_sample(), pick_sample());
                end
            end else begin
                nb = $urandom_range(1, 4);
                repeat (nb) begin
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                                      : $urandom_range(0, 12);
                    repeat (len) begin
                        r   = $urandom_range(0, 19);
                        act = (r == 0) ? ACT_UNUSED : (r < 14) ? ACT_PAIR : ACT_WEIGHT;
                        send_req(act, pick_sample(), pick_sample());
                    end
                    // Now and then the sums are left standing into the next setting.
                    if ($urandom_range(0, 9) != 0)
                        send_req(ACT_FINISH, pick_sample(), pick_sample());
                end
            end
            phase++;
        end

        // A few hundred largest squares push the dropout product past the top.
        set_cfg(MODE_DROP, '0, CFG_MAX);
        no_idle = 1'b1;
        repeat (300) send_req(ACT_PAIR, S_MAX, S_MIN);
        send_req(ACT_FINISH, '0, '0);
        no_idle = 1'b0;

        wait_idle();
        repeat (SETTLE) @(posedge i_clk);

        $display("Sent %0d pair, weight and finish requests, %0d ignored ones, %0d register writes.",
                 n_items, n_ignored, n_writes);
        $display("Compared %0d losses, %0d of them flagged as saturated.", losses, sat_losses);
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/rla_pkg.sv
hw/rtl/rla_req_if.sv
hw/rtl/rla_res_if.sv
hw/rtl/regularized_loss_accumulator.sv
tb/tb_loss_checker.sv
tb/tb_top.sv
